@@ hw/rtl/rowf_pkg.sv @@
// shared types and constants for the rank-order window filter
package rowf_pkg;

    localparam int WINDOW_SIZE = 3;
    localparam int MAX_WIDTH   = 1024;

    localparam int WIN_LEN  = WINDOW_SIZE * WINDOW_SIZE;
    localparam int HALF_WIN = WINDOW_SIZE / 2;
    localparam int RANK_W   = $clog2(WIN_LEN);

    localparam int PIX_W = 16;
    localparam int DIM_W = 11;
    localparam int CRD_W = 10;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int POS_W = ((COL_W > DIM_W) ? COL_W : DIM_W) + 1;
    localparam int LS_W  = PIX_W * (WINDOW_SIZE - 1);

    localparam int FIFO_AW    = 3;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;
    localparam int PEND_W     = FIFO_AW + 2;

    localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(480);

    typedef logic signed [PIX_W-1:0] pixel_t;

    typedef enum logic [1:0] {
        CFG_FILTER_MODE  = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_MIN    = 2'd0,
        MODE_MAX    = 2'd1,
        MODE_MEDIAN = 2'd2
    } filter_mode_t;

    typedef struct packed {
        logic signed [PIX_W-1:0] filtered;
        logic [CRD_W-1:0]        centre_row;
        logic [CRD_W-1:0]        centre_col;
        logic                    frame_done;
    } result_t;

endpackage

@@ hw/rtl/rank_order_window_filter.sv @@
// top level: streaming 3x3 min / max / median filter over a raster pixel stream
// a pixel's result passes stage 1, the stage 2 window, stages 3 and 4 and the result queue before it is offered
// throughput: one pixel per cycle when not stalled, set by one line memory read and write per cycle
// stall: pixel_stall rises only when the 8-entry result queue plus items in flight would overflow
// reset: clears position, configuration, pipeline flags and result queue
// reset: the line memory is not cleared, there is no clearing pass after reset
module rank_order_window_filter
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [rowf_pkg::DIM_W-1:0]          cfg_data,
    // pixel channel
    input  logic                                pixel_valid,
    output logic                                pixel_stall,
    input  rowf_pkg::pixel_t                    pixel,
    input  logic                                frame_start,
    // result channel
    output logic                                result_valid,
    input  logic                                result_stall,
    output rowf_pkg::pixel_t                    filtered,
    output logic [rowf_pkg::CRD_W-1:0]          centre_row,
    output logic [rowf_pkg::CRD_W-1:0]          centre_col,
    output logic                                frame_done
);

    localparam int N  = rowf_pkg::WINDOW_SIZE;
    localparam int WL = rowf_pkg::WIN_LEN;
    localparam int PW = rowf_pkg::PIX_W;
    localparam int SW = rowf_pkg::POS_W;

    // configuration registers
    logic [1:0]                   filter_mode_reg;
    logic [rowf_pkg::DIM_W-1:0]   image_width_reg;
    logic [rowf_pkg::DIM_W-1:0]   image_height_reg;

    // raster position of the next pixel
    logic [rowf_pkg::COL_W-1:0]   col_reg, col_next;
    logic [rowf_pkg::DIM_W-1:0]   row_reg, row_next;

    // line memory: one word per column, holding the two earlier rows
    logic [rowf_pkg::LS_W-1:0]    line_mem [rowf_pkg::MAX_WIDTH];
    logic [rowf_pkg::LS_W-1:0]    rd_data_reg;
    logic [rowf_pkg::LS_W-1:0]    fwd_data_reg;
    logic                         fwd_hit_reg;
    logic [rowf_pkg::LS_W-1:0]    wr_data;

    // stage 1: pixel waiting for its line memory word
    logic                         s1_valid_reg;
    logic                         s1_emit_reg;
    logic [rowf_pkg::COL_W-1:0]   s1_col_reg;
    rowf_pkg::pixel_t             s1_pix_reg;
    rowf_pkg::result_t            s1_meta_reg;

    // window registers, index row * N + column
    rowf_pkg::pixel_t             window_reg [WL];
    rowf_pkg::pixel_t             colv [N];

    // stage 2: window complete, build the compare matrix
    logic                         s2_vld_reg;
    rowf_pkg::result_t            s2_meta_reg;
    logic [WL-1:0]                cmp_next [WL];

    // stage 3: count ranks
    logic                         s3_vld_reg;
    rowf_pkg::result_t            s3_meta_reg;
    logic [WL-1:0]                s3_cmp_reg [WL];
    rowf_pkg::pixel_t             s3_val_reg [WL];
    logic [rowf_pkg::RANK_W-1:0]  rank_cnt [WL];
    logic [rowf_pkg::RANK_W-1:0]  target_rank;
    logic [WL-1:0]                hit_next;

    // stage 4: pick the element of the wanted rank
    logic                         s4_vld_reg;
    rowf_pkg::result_t            s4_meta_reg;
    logic [WL-1:0]                s4_hit_reg;
    rowf_pkg::pixel_t             s4_val_reg [WL];
    rowf_pkg::pixel_t             sel_value;
    rowf_pkg::result_t            push_entry;

    // result queue
    rowf_pkg::result_t            fifo_mem [rowf_pkg::FIFO_DEPTH];
    logic [rowf_pkg::FIFO_AW-1:0] wr_ptr_reg;
    logic [rowf_pkg::FIFO_AW-1:0] rd_ptr_reg;
    logic [rowf_pkg::FIFO_AW:0]   count_reg, count_next;
    logic [rowf_pkg::PEND_W-1:0]  pending;
    logic                         push, pop;

    // position logic
    logic                         accept;
    logic [SW-1:0]                w_eff, h_eff;
    logic [SW-1:0]                c0, r0, c1, r1, c_cur, r_cur, cn, rn;
    logic                         emit_cur;
    rowf_pkg::result_t            meta_cur;

    assign cfg_ready = 1'b1;
    assign accept    = pixel_valid && !pixel_stall;

    // configuration writes, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_mode_reg  <= rowf_pkg::MODE_MEDIAN;
            image_width_reg  <= rowf_pkg::RESET_WIDTH;
            image_height_reg <= rowf_pkg::RESET_HEIGHT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rowf_pkg::CFG_FILTER_MODE:  filter_mode_reg  <= cfg_data[1:0];
                rowf_pkg::CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                rowf_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default:                    filter_mode_reg  <= filter_mode_reg;
            endcase
        end
    end

    // raster position of the incoming pixel and of the one after it
    always_comb
    begin
        // zero size counts as one, width saturates at the line memory depth
        if (image_width_reg == '0)
            w_eff = SW'(1);
        else if (32'(image_width_reg) > rowf_pkg::MAX_WIDTH)
            w_eff = SW'(rowf_pkg::MAX_WIDTH);
        else
            w_eff = SW'(image_width_reg);
        h_eff = (image_height_reg == '0) ? SW'(1) : SW'(image_height_reg);

        c0 = frame_start ? '0 : SW'(col_reg);
        r0 = frame_start ? '0 : SW'(row_reg);
        // column left past a shrunk width starts the next row
        if (c0 >= w_eff)
        begin
            c1 = '0;
            r1 = r0 + SW'(1);
        end
        else
        begin
            c1 = c0;
            r1 = r0;
        end
        r_cur = (r1 >= h_eff) ? '0 : r1;
        c_cur = c1;

        cn = c_cur + SW'(1);
        rn = r_cur;
        if (cn >= w_eff)
        begin
            cn = '0;
            rn = r_cur + SW'(1);
            if (rn >= h_eff)
                rn = '0;
        end
        col_next = rowf_pkg::COL_W'(cn);
        row_next = rowf_pkg::DIM_W'(rn);

        // window wholly inside the image
        emit_cur = (r_cur >= SW'(N - 1)) && (c_cur >= SW'(N - 1));
        meta_cur.filtered   = '0;
        meta_cur.centre_row = rowf_pkg::CRD_W'(r_cur - SW'(rowf_pkg::HALF_WIN));
        meta_cur.centre_col = rowf_pkg::CRD_W'(c_cur - SW'(rowf_pkg::HALF_WIN));
        meta_cur.frame_done = (r_cur == h_eff - SW'(1)) && (c_cur == w_eff - SW'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line memory: read at accept, write back from stage 1 in the following cycle
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            line_mem[s1_col_reg] <= wr_data;
        if (accept)
            rd_data_reg <= line_mem[rowf_pkg::COL_W'(c_cur)];
    end

    // same column back to back: the write lands at the read edge, take it directly
    always_ff @(posedge clk)
    begin
        fwd_data_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end
        else
        begin
            fwd_hit_reg  <= s1_valid_reg && (s1_col_reg == rowf_pkg::COL_W'(c_cur));
            s1_valid_reg <= accept;
            s1_emit_reg  <= accept && emit_cur;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg  <= rowf_pkg::COL_W'(c_cur);
            s1_pix_reg  <= pixel;
            s1_meta_reg <= meta_cur;
        end
    end

    // column of the window: stored rows oldest first, then the new pixel
    always_comb
    begin
        for (int k = 0; k < N - 1; k++)
        begin
            colv[k] = fwd_hit_reg ? fwd_data_reg[k*PW +: PW] : rd_data_reg[k*PW +: PW];
        end
        colv[N-1] = s1_pix_reg;
        for (int k = 0; k < N - 1; k++)
        begin
            wr_data[k*PW +: PW] = colv[k+1];
        end
    end

    // window slides one column left, new column enters at the right
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            for (int k = 0; k < N; k++)
            begin
                for (int j = 0; j < N - 1; j++)
                begin
                    window_reg[k*N + j] <= window_reg[k*N + j + 1];
                end
                window_reg[k*N + N - 1] <= colv[k];
            end
        end
    end

    // stage 2: element j counts against element i if smaller, ties broken by index
    always_comb
    begin
        for (int i = 0; i < WL; i++)
        begin
            for (int j = 0; j < WL; j++)
            begin
                if (j == i)
                    cmp_next[i][j] = 1'b0;
                else if (j < i)
                    cmp_next[i][j] = window_reg[j] <= window_reg[i];
                else
                    cmp_next[i][j] = window_reg[j] < window_reg[i];
            end
        end
    end

    // stage 3: rank of each element is its count of smaller elements, matched against the mode's target rank
    always_comb
    begin
        case (filter_mode_reg)
            rowf_pkg::MODE_MIN: target_rank = '0;
            rowf_pkg::MODE_MAX: target_rank = rowf_pkg::RANK_W'(WL - 1);
            default:            target_rank = rowf_pkg::RANK_W'(WL / 2);
        endcase
        for (int i = 0; i < WL; i++)
        begin
            rank_cnt[i] = '0;
            for (int j = 0; j < WL; j++)
            begin
                rank_cnt[i] = rank_cnt[i] + rowf_pkg::RANK_W'(s3_cmp_reg[i][j]);
            end
            hit_next[i] = (rank_cnt[i] == target_rank);
        end
    end

    // stage 4: ranks are unique, so exactly one element hits
    always_comb
    begin
        sel_value = '0;
        for (int i = 0; i < WL; i++)
        begin
            if (s4_hit_reg[i])
                sel_value = sel_value | s4_val_reg[i];
        end
        push_entry          = s4_meta_reg;
        push_entry.filtered = sel_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s1_emit_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_meta_reg <= s1_meta_reg;
        s3_meta_reg <= s2_meta_reg;
        s4_meta_reg <= s3_meta_reg;
        s4_hit_reg  <= hit_next;
        for (int i = 0; i < WL; i++)
        begin
            s3_cmp_reg[i] <= cmp_next[i];
            s3_val_reg[i] <= window_reg[i];
            s4_val_reg[i] <= s3_val_reg[i];
        end
    end

    // result queue, decouples the result stall from the pixel side
    assign push = s4_vld_reg;
    assign pop  = result_valid && !result_stall;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (!push && pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[wr_ptr_reg] <= push_entry;
    end

    // reserve a queue slot for every result still in the pipeline
    assign pending = rowf_pkg::PEND_W'(count_reg)
                   + rowf_pkg::PEND_W'(s1_emit_reg)
                   + rowf_pkg::PEND_W'(s2_vld_reg)
                   + rowf_pkg::PEND_W'(s3_vld_reg)
                   + rowf_pkg::PEND_W'(s4_vld_reg);
    assign pixel_stall = (pending >= rowf_pkg::PEND_W'(rowf_pkg::FIFO_DEPTH));

    assign result_valid = (count_reg != '0);
    assign filtered     = fifo_mem[rd_ptr_reg].filtered;
    assign centre_row   = fifo_mem[rd_ptr_reg].centre_row;
    assign centre_col   = fifo_mem[rd_ptr_reg].centre_col;
    assign frame_done   = fifo_mem[rd_ptr_reg].frame_done;

endmodule

@@ hw/rtl/rowf_checker.sv @@
// port-level checks for the rank-order window filter, bound to the top level
module rowf_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        pixel_valid,
    input logic                        pixel_stall,
    input logic                        result_valid,
    input logic                        result_stall,
    input rowf_pkg::pixel_t            filtered,
    input logic [rowf_pkg::CRD_W-1:0]  centre_row,
    input logic [rowf_pkg::CRD_W-1:0]  centre_col,
    input logic                        frame_done
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(filtered)
            && $stable(centre_row) && $stable(centre_col) && $stable(frame_done))
    else $error("stalled result changed");

    // back pressure only builds up after a pixel was taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pixel_stall) |-> $past(pixel_valid && !pixel_stall))
    else $error("pixel stall rose without a preceding accept");

    // an empty queue fills only from an earlier accepted pixel that has passed stages 1 to 4
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(pixel_valid && !pixel_stall, 5))
    else $error("result appeared without matching pixel");

    // the last result of a frame sits at least one column in from the left edge and one row down from the top
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && frame_done |-> centre_col != '0 && centre_row != '0)
    else $error("frame end result at border position");

endmodule

bind rank_order_window_filter rowf_checker u_rowf_checker (.*);

@@ tb/sv/tb_rank_order_window_filter.sv @@
// self-checking testbench for the rank-order window filter
module tb_rank_order_window_filter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 11;
    // leave some margin after the pipeline drains before touching registers
    localparam int SETTLE_CYCLES  = 10;
    // worst quiet stretch is a long stall or sender gap
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 900;
    localparam int MAX_REPORTS    = 100;

    // register index with no register behind it, writes are ignored
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    // mode code outside the enum, filters as the median
    localparam logic [1:0] MODE_ALIAS = 2'd3;

    // flavors of random pixel values
    localparam int VAL_FULL    = 0;   // whole signed range
    localparam int VAL_NARROW  = 1;   // a few values around zero, many ties
    localparam int VAL_EXTREME = 2;   // rails and values next to zero

    typedef struct {
        bit                   is_write;
        logic [1:0]           reg_index;
        int                   reg_value;
        rowf_pkg::pixel_t     px;
        logic                 fs;
        bit                   typed;      // expected result written out in the row
        rowf_pkg::result_t    want;
    } directed_step_t;

    // dut ports, every input known from time zero
    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       cfg_valid    = 1'b0;
    logic                       cfg_ready;
    logic [1:0]                 cfg_index    = '0;
    logic [rowf_pkg::DIM_W-1:0] cfg_data     = '0;
    logic                       pixel_valid  = 1'b0;
    logic                       pixel_stall;
    rowf_pkg::pixel_t           pixel        = '0;
    logic                       frame_start  = 1'b0;
    logic                       result_valid;
    logic                       result_stall = 1'b0;
    rowf_pkg::pixel_t           filtered;
    logic [rowf_pkg::CRD_W-1:0] centre_row;
    logic [rowf_pkg::CRD_W-1:0] centre_col;
    logic                       frame_done;

    // local copy of the filter state and registers
    logic [1:0]                 mode_reg;
    logic [rowf_pkg::DIM_W-1:0] width_reg;
    logic [rowf_pkg::DIM_W-1:0] height_reg;
    rowf_pkg::pixel_t           line_mem [rowf_pkg::WINDOW_SIZE-1][rowf_pkg::MAX_WIDTH];
    rowf_pkg::pixel_t           win_regs [rowf_pkg::WINDOW_SIZE][rowf_pkg::WINDOW_SIZE];
    int unsigned                row_pos;
    int unsigned                col_pos;

    // filtered results still owed by the dut, oldest first
    rowf_pkg::result_t          pending_filtered [$];
    directed_step_t             directed_steps [$];

    // traffic shaping knobs, changed per stream
    int               stall_style = 1;   // 0 never stall, 1 light, 2 heavy
    bit               sender_calm = 1'b0;

    int               mismatches   = 0;
    int               pixels_sent  = 0;
    int               results_seen = 0;
    int               frame_ends   = 0;
    int               reg_writes   = 0;
    int               idle_cycles  = 0;

    rank_order_window_filter DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .frame_start  (frame_start),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .filtered     (filtered),
        .centre_row   (centre_row),
        .centre_col   (centre_col),
        .frame_done   (frame_done)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // advance the window by one pixel and rank it once it sits inside the image
    task automatic slide_window(input rowf_pkg::pixel_t px, input logic fs,
                                output bit made, output rowf_pkg::result_t res);
        int unsigned      w;
        int unsigned      h;
        int unsigned      r;
        int unsigned      c;
        rowf_pkg::pixel_t column [rowf_pkg::WINDOW_SIZE];
        rowf_pkg::pixel_t sorted [rowf_pkg::WIN_LEN];
        rowf_pkg::pixel_t v;
        int               k;
        int               j;
        w = (width_reg == 0) ? 1 :
            ((width_reg > rowf_pkg::MAX_WIDTH) ? rowf_pkg::MAX_WIDTH : width_reg);
        h = (height_reg == 0) ? 1 : height_reg;
        made = 1'b0;
        res = '0;
        if (fs)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        // a shrunk width or height pushes the position onward
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h)
            row_pos = 0;
        r = row_pos;
        c = col_pos;

        // vertical column: older rows from the line memory, newest pixel at the bottom
        for (k = 0; k < rowf_pkg::WINDOW_SIZE - 1; k++)
            column[k] = line_mem[k][c];
        column[rowf_pkg::WINDOW_SIZE-1] = px;
        for (k = 0; k < rowf_pkg::WINDOW_SIZE - 1; k++)
            line_mem[k][c] = column[k+1];
        for (k = 0; k < rowf_pkg::WINDOW_SIZE; k++)
        begin
            for (j = 0; j < rowf_pkg::WINDOW_SIZE - 1; j++)
                win_regs[k][j] = win_regs[k][j+1];
            win_regs[k][rowf_pkg::WINDOW_SIZE-1] = column[k];
        end

        if (r >= rowf_pkg::WINDOW_SIZE - 1 && c >= rowf_pkg::WINDOW_SIZE - 1)
        begin
            for (k = 0; k < rowf_pkg::WINDOW_SIZE; k++)
                for (j = 0; j < rowf_pkg::WINDOW_SIZE; j++)
                    sorted[k*rowf_pkg::WINDOW_SIZE + j] = win_regs[k][j];
            // insertion sort, ascending
            for (k = 1; k < rowf_pkg::WIN_LEN; k++)
            begin
                v = sorted[k];
                j = k - 1;
                while (j >= 0)
                begin
                    if (sorted[j] <= v)
                        break;
                    sorted[j+1] = sorted[j];
                    j--;
                end
                sorted[j+1] = v;
            end
            case (mode_reg)
                rowf_pkg::MODE_MIN: res.filtered = sorted[0];
                rowf_pkg::MODE_MAX: res.filtered = sorted[rowf_pkg::WIN_LEN-1];
                default:            res.filtered = sorted[rowf_pkg::WIN_LEN/2];
            endcase
            res.centre_row = rowf_pkg::CRD_W'(r - rowf_pkg::HALF_WIN);
            res.centre_col = rowf_pkg::CRD_W'(c - rowf_pkg::HALF_WIN);
            res.frame_done = (r == h - 1) && (c == w - 1);
            made = 1'b1;
        end

        col_pos = c + 1;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h)
                row_pos = 0;
        end
    endtask

    // sender gaps: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int roll;
        if (sender_calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic rowf_pkg::pixel_t pick_pixel(input int flavor);
        case (flavor)
            VAL_NARROW:
                return rowf_pkg::pixel_t'(int'($urandom_range(0, 6)) - 3);
            VAL_EXTREME:
                case ($urandom_range(0, 4))
                    0:       return rowf_pkg::pixel_t'(-32768);
                    1:       return rowf_pkg::pixel_t'(32767);
                    2:       return rowf_pkg::pixel_t'(-1);
                    3:       return rowf_pkg::pixel_t'(1);
                    default: return rowf_pkg::pixel_t'(0);
                endcase
            default:
                return rowf_pkg::pixel_t'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic flag_mismatch(input string what);
        if (mismatches < MAX_REPORTS)
            $display("mismatch at result %0d: %s", results_seen, what);
        mismatches++;
    endtask

    // present one pixel at a falling edge and hold it until accepted
    task automatic send_pixel(input rowf_pkg::pixel_t px, input logic fs, input bit typed,
                              input rowf_pkg::result_t want);
        int                gap;
        bit                made;
        rowf_pkg::result_t got;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            pixel_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        pixel_valid <= 1'b1;
        pixel       <= px;
        frame_start <= fs;
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
        slide_window(px, fs, made, got);
        if (typed)
            pending_filtered.push_back(want);
        else if (made)
            pending_filtered.push_back(got);
        pixels_sent++;
    endtask

    // stop sending, let every owed result come out, then let the pipe go quiet
    task automatic wait_drained();
        @(negedge clk);
        pixel_valid <= 1'b0;
        while (pending_filtered.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register writes happen only with the filter idle
    task automatic write_reg(input logic [1:0] idx, input int value);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= rowf_pkg::DIM_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            rowf_pkg::CFG_FILTER_MODE:  mode_reg   = 2'(value);
            rowf_pkg::CFG_IMAGE_WIDTH:  width_reg  = rowf_pkg::DIM_W'(value);
            rowf_pkg::CFG_IMAGE_HEIGHT: height_reg = rowf_pkg::DIM_W'(value);
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(input logic [1:0] mode, input int w, input int h);
        write_reg(rowf_pkg::CFG_FILTER_MODE, mode);
        write_reg(rowf_pkg::CFG_IMAGE_WIDTH, w);
        write_reg(rowf_pkg::CFG_IMAGE_HEIGHT, h);
    endtask

    // raster stream with random content; noisy streams get stray frame starts and pauses
    task automatic stream_pixels(input int count, input bit restart, input bit noisy);
        int   flavor;
        int   n;
        logic fs;
        if ($urandom_range(0, 9) < 6)
            flavor = VAL_FULL;
        else
            flavor = $urandom_range(0, 1) ? VAL_NARROW : VAL_EXTREME;
        sender_calm = ($urandom_range(0, 3) == 0);
        stall_style = $urandom_range(0, 2);
        for (n = 0; n < count; n++)
        begin
            if (n == 0)
                fs = restart;
            else
                fs = noisy && ($urandom_range(0, 149) == 0);
            if (noisy && $urandom_range(0, 249) == 0)
                wait_drained();
            send_pixel(pick_pixel(($urandom_range(0, 9) == 0) ? VAL_EXTREME : flavor),
                       fs, 1'b0, '0);
        end
    endtask

    function automatic void add_write(input logic [1:0] idx, input int value);
        directed_step_t s;
        s = '{default: 0};
        s.is_write  = 1'b1;
        s.reg_index = idx;
        s.reg_value = value;
        directed_steps.push_back(s);
    endfunction

    function automatic void add_pixel(input int value, input logic fs);
        directed_step_t s;
        s = '{default: 0};
        s.px = rowf_pkg::pixel_t'(value);
        s.fs = fs;
        directed_steps.push_back(s);
    endfunction

    function automatic void add_checked(input int value, input logic fs, input int filt,
                                        input int row, input int col, input logic done);
        directed_step_t s;
        s = '{default: 0};
        s.px              = rowf_pkg::pixel_t'(value);
        s.fs              = fs;
        s.typed           = 1'b1;
        s.want.filtered   = rowf_pkg::pixel_t'(filt);
        s.want.centre_row = rowf_pkg::CRD_W'(row);
        s.want.centre_col = rowf_pkg::CRD_W'(col);
        s.want.frame_done = done;
        directed_steps.push_back(s);
    endfunction

    // receiver back-pressure, changed only at falling edges
    initial
    begin : receiver_stalls
        int hold;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if (stall_style == 0 || result_stall)
            begin
                result_stall <= 1'b0;
                hold = (stall_style == 2) ? $urandom_range(0, 3) : $urandom_range(0, 12);
            end
            else if ($urandom_range(0, 99) < ((stall_style == 2) ? 50 : 20))
            begin
                result_stall <= 1'b1;
                if ($urandom_range(0, 9) == 0)
                    hold = $urandom_range(10, 40);
                else
                    hold = $urandom_range(0, 2);
            end
        end
    end

    // every accepted result against the oldest owed one
    always @(posedge clk)
    begin : result_check
        rowf_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (frame_done)
                frame_ends++;
            if (pending_filtered.size() == 0)
                flag_mismatch($sformatf("unexpected result %0d at row %0d col %0d",
                                        filtered, centre_row, centre_col));
            else
            begin
                want = pending_filtered.pop_front();
                if (filtered !== want.filtered)
                    flag_mismatch($sformatf("filtered %0d, expected %0d",
                                            filtered, want.filtered));
                if (centre_row !== want.centre_row)
                    flag_mismatch($sformatf("centre_row %0d, expected %0d",
                                            centre_row, want.centre_row));
                if (centre_col !== want.centre_col)
                    flag_mismatch($sformatf("centre_col %0d, expected %0d",
                                            centre_col, want.centre_col));
                if (frame_done !== want.frame_done)
                    flag_mismatch($sformatf("frame_done %0b, expected %0b",
                                            frame_done, want.frame_done));
            end
            results_seen++;
        end
    end

    // cycles without any handshake on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        directed_step_t row;
        int             k;
        int             w;
        int             h;
        int             count;
        int             random_sent;

        // register values after reset
        mode_reg   = rowf_pkg::MODE_MEDIAN;
        width_reg  = rowf_pkg::RESET_WIDTH;
        height_reg = rowf_pkg::RESET_HEIGHT;
        row_pos    = 0;
        col_pos    = 0;

        // smallest image, one result per frame
        add_write(rowf_pkg::CFG_IMAGE_WIDTH, 3);
        add_write(rowf_pkg::CFG_IMAGE_HEIGHT, 3);
        add_write(rowf_pkg::CFG_FILTER_MODE, rowf_pkg::MODE_MAX);
        // a single top rail among bottom rails
        add_pixel(-32768, 1'b1);
        for (k = 0; k < 7; k++)
            add_pixel(-32768, 1'b0);
        add_checked(32767, 1'b0, 32767, 1, 1, 1'b1);
        // next frame follows without frame_start after the wrap
        add_write(rowf_pkg::CFG_FILTER_MODE, rowf_pkg::MODE_MIN);
        for (k = 0; k < 8; k++)
            add_pixel(32767, 1'b0);
        add_checked(-32768, 1'b0, -32768, 1, 1, 1'b1);
        // unused mode code acts as median, frame_start cuts a frame short
        add_write(rowf_pkg::CFG_FILTER_MODE, MODE_ALIAS);
        add_pixel(100, 1'b0);
        add_pixel(3, 1'b1);
        add_pixel(-4, 1'b0);
        add_pixel(0, 1'b0);
        add_pixel(2, 1'b0);
        add_pixel(-1, 1'b0);
        add_pixel(4, 1'b0);
        add_pixel(-3, 1'b0);
        add_pixel(1, 1'b0);
        add_checked(-2, 1'b0, 0, 1, 1, 1'b1);
        // zero width acts as one column, no results
        add_write(rowf_pkg::CFG_IMAGE_WIDTH, 0);
        add_pixel(7, 1'b1);
        add_pixel(-7, 1'b0);
        // zero height acts as one row, no results
        add_write(rowf_pkg::CFG_IMAGE_WIDTH, 3);
        add_write(rowf_pkg::CFG_IMAGE_HEIGHT, 0);
        add_pixel(5, 1'b1);
        add_pixel(6, 1'b0);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < directed_steps.size(); k++)
        begin
            row = directed_steps[k];
            if (row.is_write)
                write_reg(row.reg_index, row.reg_value);
            else
                send_pixel(row.px, row.fs, row.typed, row.want);
        end

        // all-ones width saturates to the line memory size, first pixels of a wide row
        set_geometry(2'($urandom_range(0, 3)), 2047, 3);
        stream_pixels(64, 1'b1, 1'b0);

        // largest legal sizes, only the first rows, then a write to the empty index
        set_geometry(rowf_pkg::MODE_MEDIAN, 1024, 1024);
        stream_pixels(40, 1'b1, 1'b1);
        write_reg(CFG_UNUSED, $urandom_range(0, 2047));

        // images smaller than the window give nothing
        set_geometry(rowf_pkg::MODE_MIN, 2, 6);
        stream_pixels(20, 1'b1, 1'b1);
        set_geometry(rowf_pkg::MODE_MAX, 5, 2);
        stream_pixels(20, 1'b1, 1'b1);

        // shrink the width mid row, then the height mid frame
        set_geometry(rowf_pkg::MODE_MEDIAN, 8, 8);
        stream_pixels(5 * 8 + 6, 1'b1, 1'b0);
        write_reg(rowf_pkg::CFG_IMAGE_WIDTH, 4);       // column 6 is now past the row end
        stream_pixels(4, 1'b0, 1'b0);
        write_reg(rowf_pkg::CFG_IMAGE_HEIGHT, 5);      // row 7 is now past the frame end
        stream_pixels(30, 1'b0, 1'b0);

        // random small images, a few frames each, mostly clean rasters
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) < 7)
                w = $urandom_range(3, 10);
            else
                w = $urandom_range(11, 40);
            h = $urandom_range(3, 8);
            count = $urandom_range(1, 3) * w * h + $urandom_range(0, 2 * w);
            if (count > 250)
                count = 250;
            if (count > RANDOM_ITEMS - random_sent)
                count = RANDOM_ITEMS - random_sent;
            set_geometry(2'($urandom_range(0, 3)), w, h);
            stream_pixels(count, 1'b1, 1'b1);
            random_sent += count;
        end

        wait_drained();

        $display("covered %0d pixels and %0d register writes over min, max and median",
                 pixels_sent, reg_writes);
        $display("checked %0d filtered results including %0d frame ends, %0d mismatches",
                 results_seen, frame_ends, mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
